### sv/tbp_pkg.sv
// tbp_pkg: shared widths, status and register codes, item and config types
// for the tuple bucket partitioner; no dependencies
`default_nettype none

package tbp_pkg;

	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;
	localparam int BKT_W    = 8;
	localparam int FILL_W   = 15;
	localparam int OFS_W    = 16;
	localparam int ROWS_W   = 24;
	localparam int STAT_W   = 3;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// capacity divider: 16-bit dividend, 5-bit divisor, one quotient bit per cycle
	localparam int DVD_W     = 16;
	localparam int DSR_W     = 5;
	localparam int DIV_STEPS = 16;
	localparam int DCNT_W    = 5;

	localparam logic [OFS_W-1:0] HEADER_BYTES = 16'd8;

	// result status codes
	localparam logic [STAT_W-1:0] ST_PLACED = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
	localparam logic [STAT_W-1:0] ST_ENDED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD    = 3'd3;
	localparam logic [STAT_W-1:0] ST_BEGUN  = 3'd4;

	// register indexes
	localparam logic [2:0] REG_KEY_BYTES    = 3'd0;
	localparam logic [2:0] REG_TARGET_BYTE  = 3'd1;
	localparam logic [2:0] REG_VALUE_BYTES  = 3'd2;
	localparam logic [2:0] REG_BUCKET_COUNT = 3'd3;
	localparam logic [2:0] REG_BUFFER_BYTES = 3'd4;
	localparam logic [2:0] REG_ROW_LIMIT    = 3'd5;

	// register reset values
	localparam logic [3:0]  RST_KEY_BYTES    = 4'd8;
	localparam logic [2:0]  RST_TARGET_BYTE  = 3'd0;
	localparam logic [3:0]  RST_VALUE_BYTES  = 4'd4;
	localparam logic [8:0]  RST_BUCKET_COUNT = 9'd256;
	localparam logic [16:0] RST_BUFFER_BYTES = 17'd4096;
	localparam logic [23:0] RST_ROW_LIMIT    = 24'd0;

	// effective configuration seen by front and back
	typedef struct packed {
		logic [3:0]        kb;
		logic [3:0]        vb;
		logic [4:0]        tsize;
		logic [2:0]        target;
		logic [8:0]        bcount;
		logic [ROWS_W-1:0] row_limit;
		logic [FILL_W-1:0] capacity;
	} cfg_t;

	// classified item in the queue between front and back
	typedef struct packed {
		logic              is_row;
		logic              bad;
		logic [BKT_W-1:0]  bucket;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} item_t;

	function automatic logic [KEY_W-1:0] byte_mask(input logic [3:0] n);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### sv/tbp_if.sv
// tbp_in_if and tbp_out_if: valid/ready channels for rows and results
// depends on tbp_pkg
`default_nettype none

interface tbp_in_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [tbp_pkg::KEY_W-1:0] row_key;
	logic [tbp_pkg::VAL_W-1:0] row_value;

	modport source (output valid, action, row_key, row_value, input ready);
	modport sink   (input valid, action, row_key, row_value, output ready);
endinterface

interface tbp_out_if;
	logic                       valid;
	logic                       ready;
	logic [tbp_pkg::STAT_W-1:0] status;
	logic [tbp_pkg::BKT_W-1:0]  bucket;
	logic [tbp_pkg::FILL_W-1:0] slot;
	logic [tbp_pkg::OFS_W-1:0]  byte_offset;
	logic [tbp_pkg::KEY_W-1:0]  tuple_key;
	logic [tbp_pkg::VAL_W-1:0]  tuple_value;
	logic [tbp_pkg::ROWS_W-1:0] rows_taken;

	modport source (output valid, status, bucket, slot, byte_offset, tuple_key, tuple_value,
		rows_taken, input ready);
	modport sink   (input valid, status, bucket, slot, byte_offset, tuple_key, tuple_value,
		rows_taken, output ready);
endinterface

`default_nettype wire

### sv/tuple_bucket_partitioner_core.sv
// tuple_bucket_partitioner_core: a row passes the queue, the back's item register
// and result register; no item is popped before the last one fires, as set by the
// bucket count read-modify-write through the registered read port of the count ram
// after a write to a known register, rows are held off while the divider runs
// arst_n clears the queue, pass state, bucket valid bits and output register;
// registers return to their reset values with capacity preloaded
`default_nettype none

module tuple_bucket_partitioner_core #(
	parameter int MAX_BUCKETS   = 256,
	parameter int MAX_KEY_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	tbp_in_if.sink                            row_ch,
	tbp_out_if.source                         res_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tbp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [tbp_pkg::DATA_W-1:0]   pwdata,
	output logic      [tbp_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);

	// capacity for the reset registers, with key bytes clamped to this build
	localparam int RstKbEff = (8 > MAX_KEY_BYTES) ? MAX_KEY_BYTES : 8;
	localparam logic [14:0] CapReset = 15'((4096 - 8) / (RstKbEff + 4));

	// configuration registers, stored at their own widths
	logic [3:0]                 key_bytes_q;
	logic [2:0]                 target_byte_q;
	logic [3:0]                 value_bytes_q;
	logic [8:0]                 bucket_count_q;
	logic [16:0]                buffer_bytes_q;
	logic [23:0]                row_limit_q;
	logic                       div_start_q;

	logic [2:0]                 reg_idx;
	logic                       wr_en;
	logic                       wr_known;
	logic [3:0]                 kb_eff;
	logic [3:0]                 vb_eff;
	logic [8:0]                 bc_eff;
	logic [16:0]                buf_eff;
	logic [16:0]                buf_net;
	logic                       div_busy;
	logic [tbp_pkg::FILL_W-1:0] capacity;
	tbp_pkg::cfg_t              cfg;

	// queue between front and back
	logic                       push;
	logic                       pop;
	logic                       q_full;
	logic                       q_empty;
	tbp_pkg::item_t             wr_item;
	tbp_pkg::item_t             rd_item;

	// apb: zero wait states, write lands in the access cycle
	assign pready   = 1'b1;
	assign reg_idx  = paddr[4:2];
	assign wr_en    = psel && penable && pwrite && pready;
	assign wr_known = reg_idx <= tbp_pkg::REG_ROW_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q    <= tbp_pkg::RST_KEY_BYTES;
			target_byte_q  <= tbp_pkg::RST_TARGET_BYTE;
			value_bytes_q  <= tbp_pkg::RST_VALUE_BYTES;
			bucket_count_q <= tbp_pkg::RST_BUCKET_COUNT;
			buffer_bytes_q <= tbp_pkg::RST_BUFFER_BYTES;
			row_limit_q    <= tbp_pkg::RST_ROW_LIMIT;
			div_start_q    <= 1'b0;
		end else begin
			// every known write starts the capacity recompute in the following cycle
			div_start_q <= wr_en && wr_known;
			if (wr_en) begin
				unique case (reg_idx)
					tbp_pkg::REG_KEY_BYTES:    key_bytes_q    <= pwdata[3:0];
					tbp_pkg::REG_TARGET_BYTE:  target_byte_q  <= pwdata[2:0];
					tbp_pkg::REG_VALUE_BYTES:  value_bytes_q  <= pwdata[3:0];
					tbp_pkg::REG_BUCKET_COUNT: bucket_count_q <= pwdata[8:0];
					tbp_pkg::REG_BUFFER_BYTES: buffer_bytes_q <= pwdata[16:0];
					tbp_pkg::REG_ROW_LIMIT:    row_limit_q    <= pwdata[23:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			tbp_pkg::REG_KEY_BYTES:    prdata = 32'(key_bytes_q);
			tbp_pkg::REG_TARGET_BYTE:  prdata = 32'(target_byte_q);
			tbp_pkg::REG_VALUE_BYTES:  prdata = 32'(value_bytes_q);
			tbp_pkg::REG_BUCKET_COUNT: prdata = 32'(bucket_count_q);
			tbp_pkg::REG_BUFFER_BYTES: prdata = 32'(buffer_bytes_q);
			tbp_pkg::REG_ROW_LIMIT:    prdata = 32'(row_limit_q);
			default:                   prdata = '0;
		endcase
	end

	// clamp registers to their legal ranges where they are used
	always_comb begin
		if (key_bytes_q == 4'd0) begin
			kb_eff = 4'd1;
		end else if (key_bytes_q > 4'(MAX_KEY_BYTES)) begin
			kb_eff = 4'(MAX_KEY_BYTES);
		end else begin
			kb_eff = key_bytes_q;
		end

		if (value_bytes_q < 4'd4) begin
			vb_eff = 4'd4;
		end else if (value_bytes_q > 4'd8) begin
			vb_eff = 4'd8;
		end else begin
			vb_eff = value_bytes_q;
		end

		if (bucket_count_q == 9'd0) begin
			bc_eff = 9'd1;
		end else if (bucket_count_q > 9'(MAX_BUCKETS)) begin
			bc_eff = 9'(MAX_BUCKETS);
		end else begin
			bc_eff = bucket_count_q;
		end

		if (buffer_bytes_q < 17'd16) begin
			buf_eff = 17'd16;
		end else if (buffer_bytes_q > 17'd65536) begin
			buf_eff = 17'd65536;
		end else begin
			buf_eff = buffer_bytes_q;
		end
	end

	// payload bytes after the header, at most 65528
	assign buf_net = buf_eff - 17'd8;

	tbp_cap_div #(
		.CAP_RESET (CapReset)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (buf_net[tbp_pkg::DVD_W-1:0]),
		.divisor  (cfg.tsize),
		.busy     (div_busy),
		.capacity (capacity)
	);

	always_comb begin
		cfg.kb        = kb_eff;
		cfg.vb        = vb_eff;
		cfg.tsize     = 5'(kb_eff) + 5'(vb_eff);
		cfg.target    = target_byte_q;
		cfg.bcount    = bc_eff;
		cfg.row_limit = row_limit_q;
		cfg.capacity  = capacity;
	end

	// front: accept and classify, held off while capacity is stale
	tbp_front u_front (
		.row    (row_ch),
		.cfg    (cfg),
		.hold   (div_start_q || div_busy),
		.q_full (q_full),
		.push   (push),
		.item   (wr_item)
	);

	tbp_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	// back: pass state and count update, result transfer through its own register
	tbp_back #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_item  (rd_item),
		.q_empty (q_empty),
		.pop     (pop),
		.res     (res_ch)
	);

endmodule

`default_nettype wire

### sv/tbp_ram.sv
// tbp_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tbp_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/tbp_cap_div.sv
// tbp_cap_div: restoring divider for bucket capacity, one quotient bit per cycle
// depends on tbp_pkg
`default_nettype none

module tbp_cap_div #(
	parameter logic [14:0] CAP_RESET = 15'd340
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tbp_pkg::DVD_W-1:0]   dividend,
	input  wire logic [tbp_pkg::DSR_W-1:0]   divisor,
	output logic                             busy,
	output logic      [tbp_pkg::FILL_W-1:0]  capacity
);

	logic [tbp_pkg::DCNT_W-1:0] cnt_q;
	logic [tbp_pkg::DSR_W-1:0]  rem_q;
	logic [tbp_pkg::DSR_W-1:0]  dsr_q;
	logic [tbp_pkg::DVD_W-1:0]  dvd_q;
	logic [tbp_pkg::FILL_W-1:0] cap_q;

	logic [tbp_pkg::DSR_W:0]    rem_sh;
	logic                       ge;
	logic [tbp_pkg::DSR_W-1:0]  rem_nxt;
	logic [tbp_pkg::DVD_W-1:0]  dvd_nxt;

	// remainder stays below the divisor, so one extra bit covers the shift
	assign rem_sh  = {rem_q, dvd_q[tbp_pkg::DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_nxt = ge ? tbp_pkg::DSR_W'(rem_sh - {1'b0, dsr_q})
		: rem_sh[tbp_pkg::DSR_W-1:0];
	assign dvd_nxt = {dvd_q[tbp_pkg::DVD_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= CAP_RESET;
		end else if (start) begin
			cnt_q <= tbp_pkg::DCNT_W'(tbp_pkg::DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == tbp_pkg::DCNT_W'(1)) begin
				cap_q <= dvd_nxt[tbp_pkg::FILL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_nxt;
		end
	end

	assign busy     = cnt_q != '0;
	assign capacity = cap_q;

endmodule

`default_nettype wire

### sv/tbp_front.sv
// tbp_front: accepts rows, picks the bucket byte, flags bad buckets, masks payload
// depends on tbp_pkg and tbp_in_if
`default_nettype none

module tbp_front (
	tbp_in_if.sink                 row,
	input  wire tbp_pkg::cfg_t     cfg,
	input  wire logic              hold,
	input  wire logic              q_full,
	output logic                   push,
	output tbp_pkg::item_t         item
);

	logic [tbp_pkg::BKT_W-1:0] bkt;

	assign row.ready = !q_full && !hold;
	assign push      = row.valid && row.ready;
	assign bkt       = row.row_key[8*cfg.target +: 8];

	always_comb begin
		item.is_row = row.action;
		item.bucket = bkt;
		item.bad    = ({1'b0, cfg.target} >= cfg.kb) || ({1'b0, bkt} >= cfg.bcount);
		item.key    = row.row_key & tbp_pkg::byte_mask(cfg.kb);
		item.value  = row.row_value & tbp_pkg::byte_mask(cfg.vb);
	end

endmodule

`default_nettype wire

### sv/tbp_fifo.sv
// tbp_fifo: short queue of classified items between front and back
// depends on tbp_pkg
`default_nettype none

module tbp_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tbp_pkg::item_t wr_item,
	input  wire logic           pop,
	output tbp_pkg::item_t      rd_item,
	output logic                full,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tbp_pkg::item_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

### sv/tbp_back.sv
// tbp_back: per-pass state, bucket count read-modify-write and result register
// depends on tbp_pkg, tbp_out_if and tbp_ram
`default_nettype none

module tbp_back #(
	parameter int MAX_BUCKETS = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tbp_pkg::cfg_t  cfg,
	input  wire tbp_pkg::item_t q_item,
	input  wire logic           q_empty,
	output logic                pop,
	tbp_out_if.source           res
);

	localparam int IDX_W = $clog2(MAX_BUCKETS);

	localparam logic [0:0] BK_IDLE = 1'b0;
	localparam logic [0:0] BK_EXEC = 1'b1;

	logic [0:0]                 state_q;
	tbp_pkg::item_t             item_q;
	logic [MAX_BUCKETS-1:0]     valid_q;
	logic                       ended_q;
	logic [tbp_pkg::ROWS_W-1:0] rows_q;

	logic                       out_valid_q;
	logic [tbp_pkg::STAT_W-1:0] status_q;
	logic [tbp_pkg::BKT_W-1:0]  bucket_q;
	logic [tbp_pkg::FILL_W-1:0] slot_q;
	logic [tbp_pkg::OFS_W-1:0]  ofs_q;
	logic [tbp_pkg::KEY_W-1:0]  key_q;
	logic [tbp_pkg::VAL_W-1:0]  val_q;
	logic [tbp_pkg::ROWS_W-1:0] taken_q;

	logic [tbp_pkg::FILL_W-1:0] ram_rdata;
	logic [IDX_W-1:0]           idx;
	logic [tbp_pkg::FILL_W-1:0] fill;
	logic [tbp_pkg::FILL_W-1:0] fill_inc;
	logic [19:0]                prod;
	logic                       fire;
	logic                       place;
	logic                       ended_nxt;
	logic [tbp_pkg::STAT_W-1:0] status_nxt;

	assign pop  = (state_q == BK_IDLE) && !q_empty;
	assign fire = (state_q == BK_EXEC) && (!out_valid_q || res.ready);
	assign idx  = item_q.bucket[IDX_W-1:0];
	assign fill = valid_q[idx] ? ram_rdata : '0;
	assign fill_inc = fill + 1'b1;
	assign prod = 20'(fill) * 20'(cfg.tsize);

	tbp_ram #(
		.WIDTH (tbp_pkg::FILL_W),
		.DEPTH (MAX_BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fire && place),
		.waddr (idx),
		.wdata (fill_inc),
		.re    (pop),
		.raddr (q_item.bucket[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		place      = 1'b0;
		ended_nxt  = ended_q;
		status_nxt = tbp_pkg::ST_BEGUN;
		if (!item_q.is_row) begin
			ended_nxt  = 1'b0;
			status_nxt = tbp_pkg::ST_BEGUN;
		end else if (ended_q || (rows_q >= cfg.row_limit)) begin
			status_nxt = tbp_pkg::ST_ENDED;
		end else if (item_q.bad) begin
			status_nxt = tbp_pkg::ST_BAD;
		end else if (fill >= cfg.capacity) begin
			ended_nxt  = 1'b1;
			status_nxt = tbp_pkg::ST_ENDED;
		end else begin
			place = 1'b1;
			if (fill_inc == cfg.capacity) begin
				ended_nxt  = 1'b1;
				status_nxt = tbp_pkg::ST_FULL;
			end else begin
				status_nxt = tbp_pkg::ST_PLACED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			valid_q     <= '0;
			ended_q     <= 1'b0;
			rows_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (pop) begin
						state_q <= BK_EXEC;
					end
				end
				BK_EXEC: begin
					if (fire) begin
						state_q <= BK_IDLE;
						ended_q <= ended_nxt;
						if (!item_q.is_row) begin
							valid_q <= '0;
							rows_q  <= '0;
						end else if (place) begin
							valid_q[idx] <= 1'b1;
							rows_q       <= rows_q + 1'b1;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (fire) begin
			status_q <= status_nxt;
			bucket_q <= '0;
			slot_q   <= '0;
			ofs_q    <= '0;
			key_q    <= '0;
			val_q    <= '0;
			if (!item_q.is_row) begin
				taken_q <= '0;
			end else if (place) begin
				taken_q <= rows_q + 1'b1;
			end else begin
				taken_q <= rows_q;
			end
			if (place) begin
				bucket_q <= item_q.bucket;
				slot_q   <= fill;
				ofs_q    <= prod[tbp_pkg::OFS_W-1:0] + tbp_pkg::HEADER_BYTES;
				key_q    <= item_q.key;
				val_q    <= item_q.value;
			end else if (status_nxt == tbp_pkg::ST_BAD) begin
				bucket_q <= item_q.bucket;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = status_q;
	assign res.bucket      = bucket_q;
	assign res.slot        = slot_q;
	assign res.byte_offset = ofs_q;
	assign res.tuple_key   = key_q;
	assign res.tuple_value = val_q;
	assign res.rows_taken  = taken_q;

endmodule

`default_nettype wire

### sv/tbp_checker.sv
// tbp_checker: port-level assertions for tuple_bucket_partitioner_core and its bind
// depends on tbp_pkg
`default_nettype none

module tbp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        row_ready,
	input wire logic                        res_valid,
	input wire logic                        res_ready,
	input wire logic [tbp_pkg::STAT_W-1:0]  res_status,
	input wire logic [tbp_pkg::BKT_W-1:0]   res_bucket,
	input wire logic [tbp_pkg::FILL_W-1:0]  res_slot,
	input wire logic [tbp_pkg::OFS_W-1:0]   res_byte_offset,
	input wire logic [tbp_pkg::ROWS_W-1:0]  res_rows_taken,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [tbp_pkg::ADDR_W-1:0]  paddr
);

	// result held until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transfer");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_status) && $stable(res_slot)
			&& $stable(res_byte_offset) && $stable(res_rows_taken))
		else $error("stalled result changed");

	// capacity recompute must hold off rows
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[4:2] <= tbp_pkg::REG_ROW_LIMIT) |=> !row_ready)
		else $error("rows accepted while capacity is recomputed");

	// a placed tuple always lies past the buffer header
	a_ofs_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == tbp_pkg::ST_PLACED || res_status == tbp_pkg::ST_FULL)
			|-> res_byte_offset >= tbp_pkg::HEADER_BYTES && res_rows_taken != '0)
		else $error("placed tuple overlaps header");

	a_begun_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == tbp_pkg::ST_BEGUN
			|-> res_rows_taken == '0 && res_bucket == '0 && res_slot == '0)
		else $error("begin result carries nonzero fields");

endmodule

bind tuple_bucket_partitioner_core tbp_checker u_tbp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.row_ready       (row_ch.ready),
	.res_valid       (res_ch.valid),
	.res_ready       (res_ch.ready),
	.res_status      (res_ch.status),
	.res_bucket      (res_ch.bucket),
	.res_slot        (res_ch.slot),
	.res_byte_offset (res_ch.byte_offset),
	.res_rows_taken  (res_ch.rows_taken),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr)
);

`default_nettype wire
